@@ rtl/b64_pkg.sv @@
package b64_pkg;

   localparam int GroupDepth = 4;

   // decoded character classes beyond the 64 alphabet values
   localparam logic [6:0] DecSkip = 7'd64;
   localparam logic [6:0] DecPad  = 7'd65;

   localparam logic [7:0] PadChar = 8'h3D;

   typedef enum logic [0:0] {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   typedef struct packed {
      logic [5:0] bits;
      logic [2:0] count;
      logic       stopped;
   } state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } entry_type;

   typedef struct packed {
      entry_type [GroupDepth-1:0] entry;
      logic [2:0]                 count;
   } group_type;

   // 6-bit value to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   // character to 6-bit value, or a skip / pad class
   function automatic logic [6:0] dec_value(input logic [7:0] c);
      logic [6:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end else if (c == PadChar) begin
         v = DecPad;
      end else begin
         v = DecSkip;
      end
      return v;
   endfunction

   function automatic logic [5:0] low_mask(input logic [3:0] n);
      return 6'((9'd1 << n) - 9'd1);
   endfunction

endpackage

@@ rtl/b64_if.sv @@
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       out_last;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input out_valid, input out_last,
                 output ready);
endinterface

@@ rtl/b64_expand.sv @@
module b64_expand (
   input  b64_pkg::dir_type   direction,
   input  b64_pkg::state_type state,
   input  logic [7:0]         in_byte,
   input  logic               end_of_stream,
   output b64_pkg::group_type group,
   output b64_pkg::state_type next_state
);

   logic [2:0]  ecnt;
   logic [13:0] eacc;
   logic [3:0]  eshift;
   logic [2:0]  erem;
   logic [5:0]  eleft;
   logic [2:0]  dcnt;
   logic [6:0]  dval;
   logic [11:0] dacc;
   logic [3:0]  dn;
   logic [2:0]  k;

   always_comb begin
      group      = '0;
      next_state = state;
      k          = 3'd0;
      ecnt       = (state.count > 3'd4) ? 3'd4 : state.count;
      eacc       = {state.bits, in_byte};
      eshift     = {1'b0, ecnt} + 4'd2;
      erem       = 3'd0;
      eleft      = 6'd0;
      dcnt       = (state.count > 3'd6) ? 3'd6 : state.count;
      dval       = b64_pkg::dec_value(in_byte);
      dacc       = {state.bits, dval[5:0]};
      dn         = {1'b0, dcnt} + 4'd6;

      case (direction)
         b64_pkg::DIR_ENCODE: begin
            group.entry[k[1:0]] = '{b64_pkg::enc_char(6'(eacc >> eshift)), 1'b1, 1'b0};
            k = k + 3'd1;
            if (eshift == 4'd6) begin
               group.entry[k[1:0]] = '{b64_pkg::enc_char(eacc[5:0]), 1'b1, 1'b0};
               k = k + 3'd1;
               erem = 3'd0;
            end else begin
               erem = eshift[2:0];
            end
            eleft = eacc[5:0] & b64_pkg::low_mask({1'b0, erem});
            next_state.bits  = eleft;
            next_state.count = erem;
            if (end_of_stream) begin
               if (erem != 3'd0) begin
                  group.entry[k[1:0]] =
                     '{b64_pkg::enc_char(6'(eleft << (3'd6 - erem))), 1'b1, 1'b0};
                  k = k + 3'd1;
               end
               if (erem == 3'd2) begin
                  group.entry[k[1:0]] = '{b64_pkg::PadChar, 1'b1, 1'b0};
                  k = k + 3'd1;
                  group.entry[k[1:0]] = '{b64_pkg::PadChar, 1'b1, 1'b0};
                  k = k + 3'd1;
               end else if (erem == 3'd4) begin
                  group.entry[k[1:0]] = '{b64_pkg::PadChar, 1'b1, 1'b0};
                  k = k + 3'd1;
               end
            end
         end
         b64_pkg::DIR_DECODE: begin
            if (!state.stopped) begin
               if (dval == b64_pkg::DecPad) begin
                  next_state.stopped = 1'b1;
               end else if (dval != b64_pkg::DecSkip) begin
                  if (dn >= 4'd8) begin
                     dn = dn - 4'd8;
                     group.entry[k[1:0]] = '{8'(dacc >> dn), 1'b1, 1'b0};
                     k = k + 3'd1;
                  end
                  next_state.bits  = dacc[5:0] & b64_pkg::low_mask(dn);
                  next_state.count = dn[2:0];
               end
            end
            if (end_of_stream && k == 3'd0) begin
               group.entry[k[1:0]] = '{8'd0, 1'b0, 1'b0};
               k = k + 3'd1;
            end
         end
         default: begin
            k = 3'd0;
         end
      endcase

      // mark the final result of the stream and clear the stream state
      if (end_of_stream) begin
         if (k != 3'd0) begin
            group.entry[2'(k - 3'd1)].last = 1'b1;
         end
         next_state = '0;
      end
      group.count = k;
   end

endmodule

@@ rtl/b64_serialize.sv @@
module b64_serialize (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  b64_pkg::group_type group,
   output logic               free,
   output logic               out_vld,
   input  logic               out_ready,
   output b64_pkg::entry_type out_item
);

   b64_pkg::group_type grp_ff;
   logic [2:0]         rem_ff, rem_in;
   logic [1:0]         idx_ff, idx_in;
   logic               vld_ff, vld_in;
   b64_pkg::entry_type item_ff, item_in;
   logic               out_load;
   logic               move;

   assign out_load = !vld_ff || out_ready;
   assign move     = out_load && (rem_ff != 3'd0);
   assign free     = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && out_load);

   always_comb begin
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      item_in = item_ff;
      if (move) begin
         item_in = grp_ff.entry[idx_ff];
         vld_in  = 1'b1;
         idx_in  = idx_ff + 2'd1;
         rem_in  = rem_ff - 3'd1;
      end else if (out_load) begin
         vld_in = 1'b0;
      end
      if (load) begin
         rem_in = group.count;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (load) begin
         grp_ff <= group;
      end
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule

@@ rtl/base64_stream_codec.sv @@
// Streaming base64 coder, standard alphabet A-Z a-z 0-9 + / with '=' pad.
// csr_write_data selects the direction (0 encode bytes to text, 1 decode
// text to bytes); any write clears the stream state, so write it only
// between streams. Each accepted item is expanded combinationally into a
// group of zero to four results, which a group register and an output
// register hand out one per cycle on the response channel while it is
// ready. The single response port sets the pace: the next item waits
// while the group register still holds more than one result. Decode
// yields at most one result per item, so it runs at one item per cycle
// when not stalled. A new item is taken while the previous group's
// last result is still on its way out. In decode, characters outside the
// alphabet are skipped, the first '=' ends decoding for the stream, and
// the final item always yields a result marked last, with out_valid low
// when it carries no byte.
module base64_stream_codec (
   input  logic        clock,
   input  logic        reset,
   b64_req_if.sink     req_chan,
   b64_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   b64_pkg::dir_type   dir_ff;
   b64_pkg::state_type state_ff, state_in;
   b64_pkg::group_type group;
   b64_pkg::entry_type out_item;
   logic               free;
   logic               accept;

   // a transfer on the request side is taken when the group register
   // is free or drains its last result this cycle
   assign req_chan.ready = free;
   assign accept         = req_chan.valid && free;

   b64_expand u_expand (
      .direction     (dir_ff),
      .state         (state_ff),
      .in_byte       (req_chan.in_byte),
      .end_of_stream (req_chan.end_of_stream),
      .group         (group),
      .next_state    (state_in)
   );

   b64_serialize u_serialize (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .group     (group),
      .free      (free),
      .out_vld   (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   // advance stream state on each accepted item; a direction write
   // drops any stream in progress
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= b64_pkg::DIR_ENCODE;
         state_ff <= '0;
      end else if (csr_write_en) begin
         dir_ff   <= b64_pkg::dir_type'(csr_write_data);
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign rsp_chan.out_byte  = out_item.data;
   assign rsp_chan.out_valid = out_item.valid;
   assign rsp_chan.out_last  = out_item.last;

endmodule
